### design/gtr_pkg.sv
// ============================================================================
// gtr_pkg
// Shared types and constants for the glyph text renderer: register indexes,
// item codes, cursor constants, the configuration bundle and the sequencer
// state encoding.
// ============================================================================
package gtr_pkg;

    // Configuration port geometry: five registers on 8-byte boundaries.
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register indexes (paddr[5:3]).
    localparam logic [2:0] REG_FRAME_BASE   = 3'd0;
    localparam logic [2:0] REG_LINE_STRIDE  = 3'd1;
    localparam logic [2:0] REG_SCREEN_WIDTH = 3'd2;
    localparam logic [2:0] REG_GLYPH_ROWS   = 3'd3;
    localparam logic [2:0] REG_DRAW_COLOUR  = 3'd4;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PRINT = 1'b1;

    // Character and cursor constants.
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [13:0] CELL_WIDTH   = 14'd8;
    localparam logic [16:0] LINE_ADVANCE = 17'd18;
    localparam logic [16:0] Y_LIMIT      = 17'd65535;

    // Pixel offset from the frame base, in pixels.
    localparam int PIX_W = 32;

    typedef struct packed {
        logic [63:0] frame_base;
        logic [13:0] line_stride;
        logic [13:0] screen_width;
        logic [5:0]  glyph_rows;
        logic [31:0] draw_colour;
    } gtr_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PREP = 3'b010,
        ST_EMIT = 3'b100
    } gtr_state_t;

endpackage

### design/glyph_text_renderer.sv
// ============================================================================
// glyph_text_renderer
// Bitmap font character generator. Glyph rows are loaded into an on-chip
// glyph store; printed characters come out as one masked pixel-row write
// per glyph row.
// ============================================================================
//
//  Channel   Direction  Signals                                   Transfer
//  --------  ---------  ----------------------------------------  ------------------------
//  command   in         start, busy, mode, char_code,             start && !busy
//                       row_index, row_bits
//  result    out        result_valid, pixel_address, pixel_mask,  result_valid (no stall)
//                       pixel_colour, last_row
//  config    in/out     psel, penable, pwrite, paddr, pwdata,     psel && penable && pready
//                       prdata, pready
//
// A load or newline transaction completes at the edge that accepts it; busy
// never rises. A printed character runs in steps: the accepting edge captures
// the pixel offset from the cursor multiply, the PREP state forms the 64-bit
// address and reads row 0, then EMIT gives one result per cycle while the
// glyph store's single read port streams the rows. A character with zero rows
// only moves the cursor. The glyph store is not cleared at reset, so the block
// accepts transactions from the first cycle after reset. The receiver cannot stall.
//
module glyph_text_renderer #(
    parameter int MAX_GLYPH_ROWS = 32,
    parameter int CHAR_COUNT     = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Command channel.
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [7:0]                     char_code,
    input  logic [4:0]                     row_index,
    input  logic [7:0]                     row_bits,
    // Result channel.
    output logic                           result_valid,
    output logic [63:0]                    pixel_address,
    output logic [7:0]                     pixel_mask,
    output logic [31:0]                    pixel_colour,
    output logic                           last_row,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gtr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gtr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gtr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    // Store geometry. Each glyph owns MAX_GLYPH_ROWS consecutive entries.
    localparam int DEPTH  = CHAR_COUNT * MAX_GLYPH_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CHAR_W = $clog2(CHAR_COUNT);
    localparam int CNT_W  = $clog2(MAX_GLYPH_ROWS + 1);

    gtr_pkg::gtr_cfg_t  cfg;
    gtr_pkg::gtr_state_t state_reg, state_next;

    logic [12:0]             cursor_x_reg, cursor_x_next;
    logic [15:0]             cursor_y_reg, cursor_y_next;
    logic [AW-1:0]           glyph_base_reg, glyph_base_next;
    logic [CNT_W-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]        rows_reg, rows_next;
    logic [gtr_pkg::PIX_W-1:0] pix_reg, pix_next;
    logic [63:0]             addr_reg, addr_next;

    logic                    accept;
    logic                    is_load;
    logic                    is_newline;
    logic                    is_char;
    logic [8:0]              code_ext;
    logic [CHAR_W-1:0]       glyph_idx;
    logic [AW-1:0]           glyph_base;
    logic [CNT_W-1:0]        rows_sat;
    logic                    row_in_range;
    logic                    at_last;
    logic [13:0]             x_adv;
    logic [13:0]             x_wrap_test;
    logic [16:0]             y_adv;
    logic [15:0]             y_sat;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [CNT_W-1:0]        row_sel;
    logic [7:0]              ram_rdata;

    gtr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_glyph_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (row_bits),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Command decode.
    // ------------------------------------------------------------------
    assign busy       = (state_reg != gtr_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign is_load    = accept && (mode == gtr_pkg::MODE_LOAD);
    assign is_newline = accept && (mode == gtr_pkg::MODE_PRINT)
                        && (char_code == gtr_pkg::NEWLINE_CODE);
    assign is_char    = accept && (mode == gtr_pkg::MODE_PRINT)
                        && (char_code != gtr_pkg::NEWLINE_CODE);

    // The code is below 256, so a single subtract folds it into the font when CHAR_COUNT is at least 128.
    assign code_ext  = {1'b0, char_code};
    assign glyph_idx = (code_ext >= 9'(CHAR_COUNT))
                       ? CHAR_W'(code_ext - 9'(CHAR_COUNT))
                       : CHAR_W'(code_ext);
    assign glyph_base = AW'(glyph_idx) * AW'(MAX_GLYPH_ROWS);

    // Glyph rows above the store's capacity are clipped to it.
    assign rows_sat = (cfg.glyph_rows > 6'(MAX_GLYPH_ROWS))
                      ? CNT_W'(MAX_GLYPH_ROWS)
                      : CNT_W'(cfg.glyph_rows);

    assign row_in_range = ({1'b0, row_index} < 6'(MAX_GLYPH_ROWS));

    // Loads only arrive while idle, so they never collide with a character
    // that is being read out of the store.
    assign ram_we    = is_load && row_in_range;
    assign ram_waddr = glyph_base + AW'(row_index);

    // ------------------------------------------------------------------
    // Cursor update. The cursor moves as soon as a character is accepted;
    // the character's own pixel offset is captured in the same edge.
    // ------------------------------------------------------------------
    assign x_adv       = {1'b0, cursor_x_reg} + gtr_pkg::CELL_WIDTH;
    assign x_wrap_test = x_adv + gtr_pkg::CELL_WIDTH;
    assign y_adv       = {1'b0, cursor_y_reg} + gtr_pkg::LINE_ADVANCE;
    assign y_sat       = (y_adv > gtr_pkg::Y_LIMIT) ? gtr_pkg::Y_LIMIT[15:0] : y_adv[15:0];

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (is_newline)
        begin
            cursor_x_next = 13'd0;
            cursor_y_next = y_sat;
        end
        else if (is_char)
        begin
            if (x_wrap_test > cfg.screen_width)
            begin
                cursor_x_next = 13'd0;
                cursor_y_next = y_sat;
            end
            else
            begin
                cursor_x_next = x_adv[12:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Row sequencer.
    // ------------------------------------------------------------------
    assign at_last = (row_reg == rows_reg - CNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        glyph_base_next = glyph_base_reg;
        rows_next       = rows_reg;
        row_next        = row_reg;
        pix_next        = pix_reg;
        addr_next       = addr_reg;
        case (state_reg)
            gtr_pkg::ST_IDLE:
            begin
                if (is_char)
                begin
                    glyph_base_next = glyph_base;
                    rows_next       = rows_sat;
                    row_next        = '0;
                    pix_next        = gtr_pkg::PIX_W'(cursor_y_reg * cfg.line_stride)
                                      + gtr_pkg::PIX_W'(cursor_x_reg);
                    if (rows_sat != '0)
                    begin
                        state_next = gtr_pkg::ST_PREP;
                    end
                end
            end
            gtr_pkg::ST_PREP:
            begin
                addr_next  = cfg.frame_base + {30'd0, pix_reg, 2'b00};
                state_next = gtr_pkg::ST_EMIT;
            end
            gtr_pkg::ST_EMIT:
            begin
                addr_next = addr_reg + {48'd0, cfg.line_stride, 2'b00};
                row_next  = row_reg + CNT_W'(1);
                if (at_last)
                begin
                    state_next = gtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gtr_pkg::ST_IDLE;
            end
        endcase
    end

    // Read row 0 during the address cycle, then run one row ahead of the
    // result so the registered read data lines up with the current row.
    always_comb
    begin
        if ((state_reg == gtr_pkg::ST_EMIT) && !at_last)
        begin
            row_sel = row_reg + CNT_W'(1);
        end
        else
        begin
            row_sel = row_reg;
        end
    end

    assign ram_raddr = glyph_base_reg + AW'(row_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gtr_pkg::ST_IDLE;
            cursor_x_reg <= 13'd0;
            cursor_y_reg <= 16'd0;
            row_reg      <= '0;
            rows_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            row_reg      <= row_next;
            rows_reg     <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_base_reg <= glyph_base_next;
        pix_reg        <= pix_next;
        addr_reg       <= addr_next;
    end

    // ------------------------------------------------------------------
    // Result outputs.
    // ------------------------------------------------------------------
    assign result_valid  = (state_reg == gtr_pkg::ST_EMIT);
    assign pixel_address = addr_reg;
    assign pixel_mask    = ram_rdata;
    assign pixel_colour  = cfg.draw_colour;
    assign last_row      = at_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_rows_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_row |=> result_valid)
        else $error("glyph rows were not emitted in consecutive cycles");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_row |=> !busy)
        else $error("sequencer did not return to idle after the last row");

    a_char_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        is_char && (rows_sat != '0) |=> busy ##1 result_valid)
        else $error("accepted character did not reach the first row");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !ram_we)
        else $error("glyph store written while a character is being read");

endmodule

### design/gtr_ram.sv
// ============================================================================
// gtr_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read and no reset on the array.
// ============================================================================
module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/gtr_cfg.sv
// ============================================================================
// gtr_cfg
// APB configuration register file for the glyph text renderer. Writes land
// on the access cycle; reads return the stored register value.
// ============================================================================
module gtr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gtr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gtr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gtr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output gtr_pkg::gtr_cfg_t              cfg
);

    gtr_pkg::gtr_cfg_t cfg_reg;
    logic [2:0]        index;
    logic              wr_en;

    assign pready = 1'b1;
    assign index  = paddr[gtr_pkg::CFG_ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base   <= 64'd0;
            cfg_reg.line_stride  <= 14'd640;
            cfg_reg.screen_width <= 14'd640;
            cfg_reg.glyph_rows   <= 6'd16;
            cfg_reg.draw_colour  <= 32'hFFFF_FFFF;
        end
        else if (wr_en)
        begin
            case (index)
                gtr_pkg::REG_FRAME_BASE:   cfg_reg.frame_base   <= pwdata;
                gtr_pkg::REG_LINE_STRIDE:  cfg_reg.line_stride  <= pwdata[13:0];
                gtr_pkg::REG_SCREEN_WIDTH: cfg_reg.screen_width <= pwdata[13:0];
                gtr_pkg::REG_GLYPH_ROWS:   cfg_reg.glyph_rows   <= pwdata[5:0];
                gtr_pkg::REG_DRAW_COLOUR:  cfg_reg.draw_colour  <= pwdata[31:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            gtr_pkg::REG_FRAME_BASE:   prdata = cfg_reg.frame_base;
            gtr_pkg::REG_LINE_STRIDE:  prdata = {50'd0, cfg_reg.line_stride};
            gtr_pkg::REG_SCREEN_WIDTH: prdata = {50'd0, cfg_reg.screen_width};
            gtr_pkg::REG_GLYPH_ROWS:   prdata = {58'd0, cfg_reg.glyph_rows};
            gtr_pkg::REG_DRAW_COLOUR:  prdata = {32'd0, cfg_reg.draw_colour};
            default:                   prdata = '0;
        endcase
    end

endmodule
